FILE: rtl/fsbc_pkg.sv
package fsbc_pkg;

	// Register file and default geometry
	localparam int NUM_PLANE_REGS  = 6;
	localparam int PLANE_COUNT_DEF = 6;
	localparam int COORD_BITS_DEF  = 16;
	localparam int Q_FRAC          = 14;
	localparam int PLANE_FIELD_W   = 16;
	localparam int CFG_DATA_W      = 64;
	localparam int CFG_ADDR_W      = 6;
	localparam int REG_IDX_LSB     = 3;

	// Bit positions of the fields inside one plane register
	localparam int PLANE_A_LSB = 0;
	localparam int PLANE_B_LSB = 16;
	localparam int PLANE_C_LSB = 32;
	localparam int PLANE_D_LSB = 48;

	typedef logic [CFG_DATA_W-1:0] plane_t;

	typedef enum logic {
		KIND_SPHERE = 1'b0,
		KIND_BOX    = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		REG_PLANE_LEFT   = 3'd0,
		REG_PLANE_RIGHT  = 3'd1,
		REG_PLANE_BOTTOM = 3'd2,
		REG_PLANE_TOP    = 3'd3,
		REG_PLANE_FAR    = 3'd4,
		REG_PLANE_NEAR   = 3'd5
	} reg_idx_t;

endpackage

FILE: rtl/fsbc_if.sv
// Object channel: one sphere or box per transfer
interface fsbc_obj_if #(
	parameter int COORD_BITS = fsbc_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic signed [COORD_BITS-1:0] center_x;
	logic signed [COORD_BITS-1:0] center_y;
	logic signed [COORD_BITS-1:0] center_z;
	logic        [COORD_BITS-2:0] radius;
	logic signed [COORD_BITS-1:0] box_min_x;
	logic signed [COORD_BITS-1:0] box_min_y;
	logic signed [COORD_BITS-1:0] box_min_z;
	logic signed [COORD_BITS-1:0] box_max_x;
	logic signed [COORD_BITS-1:0] box_max_y;
	logic signed [COORD_BITS-1:0] box_max_z;

	modport source (
		output valid, kind, center_x, center_y, center_z, radius,
		       box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		input  ready
	);
	modport sink (
		input  valid, kind, center_x, center_y, center_z, radius,
		       box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		output ready
	);
endinterface

// Result channel: visibility flag per object
interface fsbc_res_if;
	logic valid;
	logic ready;
	logic visible;

	modport source (
		output valid, visible,
		input  ready
	);
	modport sink (
		input  valid, visible,
		output ready
	);
endinterface

FILE: rtl/frustum_sphere_box_cull_unit.sv
// An object passes the input, product and result registers; all lanes run in parallel.
// Throughput: one object per cycle while res.ready holds, with 3 multipliers per lane.
// The pipeline advances under backpressure only where a stage is empty, so an object
// can still be taken while a finished result waits, as long as some stage is empty.
// Reset clears all pipeline valid flags and sets every plane register to zero.
module frustum_sphere_box_cull_unit #(
	parameter int PLANE_COUNT = fsbc_pkg::PLANE_COUNT_DEF,
	parameter int COORD_BITS  = fsbc_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	fsbc_obj_if.sink                        obj,
	fsbc_res_if.source                      res,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fsbc_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [fsbc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [fsbc_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready
);
	import fsbc_pkg::*;

	localparam int LANES  = (PLANE_COUNT < NUM_PLANE_REGS) ? PLANE_COUNT : NUM_PLANE_REGS;
	localparam int WIDE_W = (COORD_BITS + 15 > 30) ? COORD_BITS + 15 : 30;
	localparam int SUM_W  = WIDE_W + 3;

	plane_t planes [NUM_PLANE_REGS];

	logic                         v_s1, v_s2, out_v_q, visible_q;
	logic                         en_s1, en_s2, en_out;
	logic                         is_box_s1, is_box_s2;
	logic signed [COORD_BITS-1:0] cx_s1, cy_s1, cz_s1;
	logic        [COORD_BITS-2:0] radius_s1;
	logic signed [COORD_BITS-1:0] mnx_s1, mny_s1, mnz_s1, mxx_s1, mxy_s1, mxz_s1;
	logic signed [SUM_W-1:0]      rad_ext;
	logic signed [SUM_W-1:0]      bias_s2;
	logic        [LANES-1:0]      culled;

	fsbc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.planes  (planes)
	);

	// A stage moves when it is empty or the stage after it moves
	assign en_out    = !out_v_q || res.ready;
	assign en_s2     = !v_s2 || en_out;
	assign en_s1     = !v_s1 || en_s2;
	assign obj.ready = en_s1;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= obj.valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_out) begin
				out_v_q <= v_s2;
			end
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (en_s1 && obj.valid) begin
			is_box_s1 <= (obj.kind == KIND_BOX);
			cx_s1     <= obj.center_x;
			cy_s1     <= obj.center_y;
			cz_s1     <= obj.center_z;
			radius_s1 <= obj.radius;
			mnx_s1    <= obj.box_min_x;
			mny_s1    <= obj.box_min_y;
			mnz_s1    <= obj.box_min_z;
			mxx_s1    <= obj.box_max_x;
			mxy_s1    <= obj.box_max_y;
			mxz_s1    <= obj.box_max_z;
		end
	end

	// Sphere bias: radius scaled to the Q14 distance, zero for a box
	assign rad_ext = SUM_W'($signed({1'b0, radius_s1}));

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			is_box_s2 <= is_box_s1;
			bias_s2   <= is_box_s1 ? '0 : (rad_ext <<< Q_FRAC);
		end
	end

	// One lane per tested plane
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		fsbc_plane_lane #(
			.COORD_BITS (COORD_BITS),
			.SUM_W      (SUM_W)
		) u_lane (
			.clk         (clk),
			.load_s2     (en_s2 && v_s1),
			.plane       (planes[g]),
			.is_box_s1   (is_box_s1),
			.center_x_s1 (cx_s1),
			.center_y_s1 (cy_s1),
			.center_z_s1 (cz_s1),
			.min_x_s1    (mnx_s1),
			.min_y_s1    (mny_s1),
			.min_z_s1    (mnz_s1),
			.max_x_s1    (mxx_s1),
			.max_y_s1    (mxy_s1),
			.max_z_s1    (mxz_s1),
			.is_box_s2   (is_box_s2),
			.bias_s2     (bias_s2),
			.culled      (culled[g])
		);
	end

	// Result register: visible unless some plane culls
	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			visible_q <= ~|culled;
		end
	end

	assign res.valid   = out_v_q;
	assign res.visible = visible_q;

endmodule

FILE: rtl/fsbc_plane_lane.sv
module fsbc_plane_lane #(
	parameter int COORD_BITS = fsbc_pkg::COORD_BITS_DEF,
	parameter int SUM_W      = 34
) (
	input  logic                         clk,
	input  logic                         load_s2,
	input  fsbc_pkg::plane_t             plane,
	input  logic                         is_box_s1,
	input  logic signed [COORD_BITS-1:0] center_x_s1,
	input  logic signed [COORD_BITS-1:0] center_y_s1,
	input  logic signed [COORD_BITS-1:0] center_z_s1,
	input  logic signed [COORD_BITS-1:0] min_x_s1,
	input  logic signed [COORD_BITS-1:0] min_y_s1,
	input  logic signed [COORD_BITS-1:0] min_z_s1,
	input  logic signed [COORD_BITS-1:0] max_x_s1,
	input  logic signed [COORD_BITS-1:0] max_y_s1,
	input  logic signed [COORD_BITS-1:0] max_z_s1,
	input  logic                         is_box_s2,
	input  logic signed [SUM_W-1:0]      bias_s2,
	output logic                         culled
);
	import fsbc_pkg::*;

	localparam int PROD_W = COORD_BITS + PLANE_FIELD_W;

	logic signed [PLANE_FIELD_W-1:0] coef_a, coef_b, coef_c, coef_d;
	logic signed [COORD_BITS-1:0]    pt_x, pt_y, pt_z;
	logic signed [PROD_W-1:0]        prod_x_s2, prod_y_s2, prod_z_s2;
	logic signed [SUM_W-1:0]         d_term;
	logic signed [SUM_W-1:0]         plane_dist;

	// Unpack the plane register
	assign coef_a = plane[PLANE_A_LSB +: PLANE_FIELD_W];
	assign coef_b = plane[PLANE_B_LSB +: PLANE_FIELD_W];
	assign coef_c = plane[PLANE_C_LSB +: PLANE_FIELD_W];
	assign coef_d = plane[PLANE_D_LSB +: PLANE_FIELD_W];

	// Pick the test point: sphere center, or the box vertex furthest along the normal
	always_comb begin
		if (is_box_s1) begin
			pt_x = (!coef_a[PLANE_FIELD_W-1] && (coef_a != '0)) ? max_x_s1 : min_x_s1;
			pt_y = (!coef_b[PLANE_FIELD_W-1] && (coef_b != '0)) ? max_y_s1 : min_y_s1;
			pt_z = (!coef_c[PLANE_FIELD_W-1] && (coef_c != '0)) ? max_z_s1 : min_z_s1;
		end else begin
			pt_x = center_x_s1;
			pt_y = center_y_s1;
			pt_z = center_z_s1;
		end
	end

	// Register the three normal products
	always_ff @(posedge clk) begin
		if (load_s2) begin
			prod_x_s2 <= PROD_W'(coef_a) * PROD_W'(pt_x);
			prod_y_s2 <= PROD_W'(coef_b) * PROD_W'(pt_y);
			prod_z_s2 <= PROD_W'(coef_c) * PROD_W'(pt_z);
		end
	end

	// Scaled signed distance plus the radius bias, then the cull compare
	assign d_term     = SUM_W'(coef_d) <<< Q_FRAC;
	assign plane_dist = SUM_W'(prod_x_s2) + SUM_W'(prod_y_s2) + SUM_W'(prod_z_s2) + d_term
		+ bias_s2;

	always_comb begin
		if (is_box_s2) begin
			culled = plane_dist[SUM_W-1];
		end else begin
			culled = plane_dist[SUM_W-1] || (plane_dist == '0);
		end
	end

endmodule

FILE: rtl/fsbc_cfg_regs.sv
module fsbc_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fsbc_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [fsbc_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [fsbc_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready,
	output fsbc_pkg::plane_t                    planes [fsbc_pkg::NUM_PLANE_REGS]
);
	import fsbc_pkg::*;

	plane_t   planes_q [NUM_PLANE_REGS];
	reg_idx_t reg_idx;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[REG_IDX_LSB +: 3]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign planes  = planes_q;

	// Write the addressed plane; drop writes beyond the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANE_REGS; i++) begin
				planes_q[i] <= '0;
			end
		end else if (wr_en) begin
			case (reg_idx)
				REG_PLANE_LEFT:   planes_q[REG_PLANE_LEFT]   <= pwdata;
				REG_PLANE_RIGHT:  planes_q[REG_PLANE_RIGHT]  <= pwdata;
				REG_PLANE_BOTTOM: planes_q[REG_PLANE_BOTTOM] <= pwdata;
				REG_PLANE_TOP:    planes_q[REG_PLANE_TOP]    <= pwdata;
				REG_PLANE_FAR:    planes_q[REG_PLANE_FAR]    <= pwdata;
				REG_PLANE_NEAR:   planes_q[REG_PLANE_NEAR]   <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back the addressed plane
	always_comb begin
		case (reg_idx)
			REG_PLANE_LEFT:   prdata = planes_q[REG_PLANE_LEFT];
			REG_PLANE_RIGHT:  prdata = planes_q[REG_PLANE_RIGHT];
			REG_PLANE_BOTTOM: prdata = planes_q[REG_PLANE_BOTTOM];
			REG_PLANE_TOP:    prdata = planes_q[REG_PLANE_TOP];
			REG_PLANE_FAR:    prdata = planes_q[REG_PLANE_FAR];
			REG_PLANE_NEAR:   prdata = planes_q[REG_PLANE_NEAR];
			default:          prdata = '0;
		endcase
	end

endmodule
